// ===== rtl/whaf_pkg.sv =====
// ---------------------------------------------------------------------------
// whaf_pkg: shared constants and tables for the weighted history average
// Tap weights (Q0.16, newest first) and the warm-up reciprocal table.
// ---------------------------------------------------------------------------
package whaf_pkg;

  localparam int SAMPLE_IN_W     = 16;  // sample_cm field width
  localparam int AVG_W           = 24;  // average_cm_q8 field width
  localparam int TAPS_USED_W     = 4;   // taps_used field width
  localparam int MAX_TAPS        = 10;
  localparam int TAPS_DEF        = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int TAP_IDX_W = 4;   // index into the weight / reciprocal tables
  localparam int WEIGHT_W  = 15;  // widest weight is below 2^15
  localparam int WSUM_W    = 16;  // all weights sum to 2^16

  // Normalizing multiply walks the reciprocal one digit per cycle, LSB first
  localparam int DIGIT_W      = 8;
  localparam int RECIP_DIGITS = 5;
  localparam int RECIP_W      = DIGIT_W * RECIP_DIGITS;

  function automatic logic [WEIGHT_W-1:0] tap_weight(input logic [TAP_IDX_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    case (idx)
      4'd0:    w = 15'd19661;
      4'd1:    w = 15'd14418;
      4'd2:    w = 15'd10486;
      4'd3:    w = 15'd7864;
      4'd4:    w = 15'd6554;
      4'd5:    w = 15'd2621;
      4'd6:    w = 15'd1311;
      4'd7:    w = 15'd1311;
      4'd8:    w = 15'd655;
      4'd9:    w = 15'd655;
      default: w = '0;
    endcase
    return w;
  endfunction

  // ceil(2^48 / W(n)), W(n) being the sum of the n newest weights
  function automatic logic [RECIP_W-1:0] recip_of(input logic [TAP_IDX_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 40'd14316412020;
      4'd2:    r = 40'd8259484631;
      4'd3:    r = 40'd6316054678;
      4'd4:    r = 40'd5368688641;
      4'd5:    r = 40'd4772137340;
      4'd6:    r = 40'd4569102278;
      4'd7:    r = 40'd4473892978;
      4'd8:    r = 40'd4382570559;
      4'd9:    r = 40'd4338326733;
      4'd10:   r = 40'd4294967296;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/whaf_norm.sv =====
// ---------------------------------------------------------------------------
// whaf_norm: digit-serial normalizing multiply
// Computes floor(acc * recip / 2^40), one 8-bit reciprocal digit per cycle.
// ---------------------------------------------------------------------------
module whaf_norm
  import whaf_pkg::*;
#(
  parameter int ACC_W = SAMPLE_BITS_DEF + WSUM_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ACC_W-1:0]   acc_in,
  input  logic [RECIP_W-1:0] recip_in,
  output logic               done,
  output logic [AVG_W-1:0]   quot
);

  localparam int CNT_W = $clog2(RECIP_DIGITS + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-1:0]   mcand;
  logic [RECIP_W-1:0] rsh;
  logic [ACC_W-1:0]   part;

  logic [ACC_W+DIGIT_W-1:0] pp;
  logic [ACC_W+DIGIT_W:0]   sum;
  logic                     last;

  assign pp   = mcand * rsh[DIGIT_W-1:0];
  assign sum  = {{(DIGIT_W+1){1'b0}}, part} + {1'b0, pp};
  assign last = (cnt == CNT_W'(RECIP_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Low digits drop off exactly; what remains after all digits is the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= acc_in;
      rsh   <= recip_in;
      part  <= '0;
    end else if (busy) begin
      rsh  <= rsh >> DIGIT_W;
      part <= sum[ACC_W+DIGIT_W-1:DIGIT_W];
    end
  end

  assign quot = part[AVG_W-1:0];

endmodule

// ===== rtl/weighted_history_average_filter_core.sv =====
// ---------------------------------------------------------------------------
// weighted_history_average_filter_core: 10-tap weighted moving average
//
// Slave stream (s_*) takes one range sample per transfer; master stream (m_*)
// returns one weighted average per sample, with the number of taps it used.
// The newest sample weighs 0.30, the oldest 0.01; until TAPS samples have
// arrived only those received are used, normalized by their weight sum.
// Timing: a sample is taken only while the core is idle. The tap loop runs
// one tap per cycle (single multiply-accumulate on a rotating sample line),
// then the normalizing multiply works through the five 8-bit reciprocal
// digits, one per cycle. The core takes no new sample until the result of
// the current one has been loaded into the output register.
// The result register frees the core from the receiver: if an earlier result
// is still held with m_tready low, the finished result waits in a hold state until the old output transfers.
// Reset clears the fill level; the sample line holds no valid data until
// written and needs no clearing.
// ---------------------------------------------------------------------------
module weighted_history_average_filter_core
  import whaf_pkg::*;
#(
  parameter int TAPS        = TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample_cm
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [23:0] average_cm_q8, [27:24] taps_used, [31:28] zero
);

  localparam int SAMP_W = (SAMPLE_BITS < SAMPLE_IN_W) ? SAMPLE_BITS : SAMPLE_IN_W;
  localparam int ACC_W  = SAMP_W + WSUM_W;
  localparam int CNT_W  = $clog2(TAPS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TAP  = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] tap_cnt;
  logic [CNT_W-1:0] fill;
  logic [ACC_W-1:0] acc;
  logic [SAMP_W-1:0] ring [TAPS];

  logic [AVG_W-1:0]       avg;
  logic [TAPS_USED_W-1:0] taps_out;

  logic                       in_xfer;
  logic                       out_free;
  logic                       last_tap;
  logic [SAMP_W+WEIGHT_W-1:0] tap_prod;
  logic [SAMP_W+WEIGHT_W-1:0] tap_term;
  logic [ACC_W-1:0]           acc_next;
  logic                       norm_start;
  logic                       norm_done;
  logic [AVG_W-1:0]           norm_quot;
  logic                       out_load;

  assign s_tready = (state == ST_IDLE) && !rst;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign last_tap = (tap_cnt == CNT_W'(TAPS - 1));

  // ring[0] is always the sample for the current tap; unfilled taps add zero
  assign tap_prod = ring[0] * tap_weight(TAP_IDX_W'(tap_cnt));
  assign tap_term = (tap_cnt < fill) ? tap_prod : '0;
  assign acc_next = acc + ACC_W'(tap_term);

  assign norm_start = (state == ST_TAP) && last_tap;
  assign out_load   = ((state == ST_NORM) && norm_done && out_free) ||
                      ((state == ST_HOLD) && out_free);

  whaf_norm #(
    .ACC_W (ACC_W)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (norm_start),
    .acc_in   (acc_next),
    .recip_in (recip_of(TAP_IDX_W'(fill))),
    .done     (norm_done),
    .quot     (norm_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
      fill    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            tap_cnt <= '0;
            if (fill != CNT_W'(TAPS)) begin
              fill <= fill + 1'b1;
            end
            state <= ST_TAP;
          end
        end
        ST_TAP: begin
          tap_cnt <= tap_cnt + 1'b1;
          if (last_tap) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (norm_done) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sample line: shift in on a transfer, rotate once per tap (TAPS rotations
  // bring it back to newest-first order)
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ring[0] <= s_tdata[SAMP_W-1:0];
      for (int k = 1; k < TAPS; k++) begin
        ring[k] <= ring[k-1];
      end
    end else if (state == ST_TAP) begin
      for (int k = 0; k < TAPS - 1; k++) begin
        ring[k] <= ring[k+1];
      end
      ring[TAPS-1] <= ring[0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc <= '0;
    end else if (state == ST_TAP) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg      <= norm_quot;
      taps_out <= TAPS_USED_W'(fill);
    end
  end

  assign m_tdata = {4'b0000, taps_out, avg};

  a_done_in_norm: assert property (@(posedge clk) disable iff (rst)
    norm_done |-> state == ST_NORM)
    else $error("normalizer finished outside the normalize state");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(TAPS))
    else $error("fill level beyond tap count");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (fill != CNT_W'(TAPS)) |=> fill == $past(fill) + 1'b1)
    else $error("fill level did not advance on a sample transfer");

  a_taps_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (taps_out != '0) && (taps_out <= TAPS_USED_W'(TAPS)))
    else $error("taps_used out of range on a valid result");

endmodule
